// ===== hw/rtl/ora_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle repulsion adjuster package
// Shared constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ora_pkg;

    localparam int MAX_OBSTACLES_DEF = 16;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 30;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [RADIUS_W-1:0] MARGIN_RESET = 30'd131072;
    localparam logic [31:0]         NEAR_LIMIT   = 32'd655;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int STEP_W     = 5;

    localparam int OP_CLEAR_BIT  = 0;
    localparam int OP_ADJUST_BIT = 1;

    localparam logic [STATUS_W-1:0] ST_ADJUSTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic latch;
        logic table_op;
        logic adj_init;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic sum;
        logic sq_step;
        logic ld_u;
        logic ld_t;
        logic div_step;
        logic acc;
        logic next;
        logic emit_adj;
        logic comp_y;
    } t_cmd;

    typedef struct packed {
        logic adjust;
        logic empty;
        logic far;
        logic reject;
        logic last;
    } t_sts;

endpackage

// ===== hw/rtl/ora_ctrl.sv =====
// ----------------------------------------------------------------------------
// Obstacle repulsion adjuster controller
// Sequences the table operations and the per-obstacle repulsion steps.
// ----------------------------------------------------------------------------
module ora_ctrl import ora_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_SQX    = 4'd4;
    localparam logic [3:0] S_SQY    = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_SQRT   = 4'd7;
    localparam logic [3:0] S_CHK    = 4'd8;
    localparam logic [3:0] S_LDU    = 4'd9;
    localparam logic [3:0] S_DIVU   = 4'd10;
    localparam logic [3:0] S_MUL    = 4'd11;
    localparam logic [3:0] S_DIVT   = 4'd12;
    localparam logic [3:0] S_ACC    = 4'd13;
    localparam logic [3:0] S_NEXT   = 4'd14;
    localparam logic [3:0] S_FINISH = 4'd15;

    localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(SQRT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_comp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_comp  = r_comp;
        o_cmd   = '0;
        o_cmd.comp_y = r_comp;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.adjust) begin
                    o_cmd.adj_init = 1'b1;
                    n_state = i_sts.empty ? S_FINISH : S_READ;
                end else begin
                    o_cmd.table_op = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = i_sts.far ? S_NEXT : S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_step    = SQ_LAST;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_step        = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_comp  = 1'b0;
                n_state = i_sts.reject ? S_NEXT : S_LDU;
            end
            S_LDU: begin
                o_cmd.ld_u = 1'b1;
                n_step     = DIV_LAST;
                n_state    = S_DIVU;
            end
            S_DIVU: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.ld_t = 1'b1;
                n_step     = DIV_LAST;
                n_state    = S_DIVT;
            end
            S_DIVT: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!r_comp) begin
                    n_comp  = 1'b1;
                    n_state = S_LDU;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_sts.last ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                o_cmd.emit_adj = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_adj |=> (r_state == S_IDLE))
        else $error("controller not idle after emitting a result");
    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_step == '0) |=> (r_state == S_CHK))
        else $error("square root did not finish after its last step");
`endif

endmodule

// ===== hw/rtl/ora_datapath.sv =====
// ----------------------------------------------------------------------------
// Obstacle repulsion adjuster datapath
// Obstacle table, distance, square root, division and repulsion accumulation.
// ----------------------------------------------------------------------------
module ora_datapath import ora_pkg::*; #(
    parameter  int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1),
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
    localparam int SUM_W = IDX_W + 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [COORD_W-1:0]  i_pos_x,
    input  logic signed [COORD_W-1:0]  i_pos_y,
    input  logic [RADIUS_W-1:0]        i_obstacle_radius,
    input  logic                       i_cfg_we,
    input  logic [RADIUS_W-1:0]        i_cfg_data,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [COORD_W-1:0]  o_adjusted_x,
    output logic signed [COORD_W-1:0]  o_adjusted_y,
    output logic                       o_saturated,
    output logic [CNT_W-1:0]           o_stored_count
);

    logic [RADIUS_W-1:0] r_margin;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx;
    logic [OP_W-1:0]     r_op;
    logic [31:0]         r_px, r_py;
    logic [RADIUS_W-1:0] r_rad_in;

    logic [31:0]         mem_cx [MAX_OBSTACLES];
    logic [31:0]         mem_cy [MAX_OBSTACLES];
    logic [RADIUS_W-1:0] mem_sz [MAX_OBSTACLES];
    logic [31:0]         r_rd_cx, r_rd_cy;
    logic [RADIUS_W-1:0] r_rd_sz;

    logic [31:0] r_r, r_mx, r_my;
    logic        r_negx, r_negy, r_far, r_ovf;
    logic [63:0] r_sx, r_sy;
    logic [63:0] r_sq_rad;
    logic [33:0] r_sq_rem;
    logic [31:0] r_sq_root;
    logic [31:0] r_drem, r_ddiv;
    logic [DIV_STEPS-1:0] r_dlo;
    logic signed [SUM_W-1:0] r_sumx, r_sumy;

    logic full;
    logic [32:0] dx, dy, mx, my;
    logic [31:0] reach;
    logic [31:0] mul_op;
    logic [63:0] mul_res;
    logic [64:0] d2;
    logic [34:0] sq_rem2, sq_trial, sq_diff;
    logic        sq_ge;
    logic [32:0] dv_tmp, dv_diff;
    logic        dv_ge;
    logic [31:0] m_sel;
    logic [48:0] prod_t;
    logic signed [SUM_W-1:0] term;
    logic [32:0] clip_x, clip_y;

    function automatic logic [32:0] clip34(input logic signed [33:0] v);
        logic [32:0] res;
        res = {1'b0, v[31:0]};
        if (!v[33] && (v[32] || v[31])) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v[33] && !(v[32] && v[31])) begin
            res = {1'b1, 32'h8000_0000};
        end
        return res;
    endfunction

    assign full = (r_count == CNT_W'(MAX_OBSTACLES));

    always_comb begin
        n_count = r_count;
        if (i_cmd.table_op) begin
            if (r_op[OP_CLEAR_BIT]) begin
                n_count = '0;
            end else if (!full) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign dx = {r_px[31], r_px} - {r_rd_cx[31], r_rd_cx};
    assign dy = {r_py[31], r_py} - {r_rd_cy[31], r_rd_cy};
    assign mx = dx[32] ? (33'd0 - dx) : dx;
    assign my = dy[32] ? (33'd0 - dy) : dy;
    assign reach = {2'b00, r_rd_sz} + {1'b0, r_margin, 1'b0};

    assign mul_op  = i_cmd.sq_y ? r_my : r_mx;
    assign mul_res = mul_op * mul_op;
    assign d2      = {1'b0, r_sx} + {1'b0, r_sy};

    assign sq_rem2  = {r_sq_rem[32:0], r_sq_rad[63:62]};
    assign sq_trial = {1'b0, r_sq_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign sq_diff  = sq_rem2 - sq_trial;

    assign dv_tmp  = {r_drem, r_dlo[DIV_STEPS-1]};
    assign dv_ge   = (dv_tmp >= {1'b0, r_ddiv});
    assign dv_diff = dv_tmp - {1'b0, r_ddiv};

    assign m_sel  = i_cmd.comp_y ? r_my : r_mx;
    assign prod_t = r_dlo * (r_r - r_sq_root);

    assign term = (i_cmd.comp_y ? r_negy : r_negx)
                ? (SUM_W'(0) - SUM_W'(r_dlo)) : SUM_W'(r_dlo);

    assign clip_x = clip34($signed({{2{r_px[31]}}, r_px})
                  + $signed({{(34-SUM_W){r_sumx[SUM_W-1]}}, r_sumx}));
    assign clip_y = clip34($signed({{2{r_py[31]}}, r_py})
                  + $signed({{(34-SUM_W){r_sumy[SUM_W-1]}}, r_sumy}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
            r_count  <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_margin <= i_cfg_data;
            end
            r_count <= n_count;
            o_valid <= i_cmd.table_op || i_cmd.emit_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.table_op && !r_op[OP_CLEAR_BIT] && !full) begin
            mem_cx[r_count[IDX_W-1:0]] <= r_px;
            mem_cy[r_count[IDX_W-1:0]] <= r_py;
            mem_sz[r_count[IDX_W-1:0]] <= r_rad_in;
        end
        r_rd_cx <= mem_cx[r_idx];
        r_rd_cy <= mem_cy[r_idx];
        r_rd_sz <= mem_sz[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_op;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_rad_in <= i_obstacle_radius;
        end
        if (i_cmd.adj_init) begin
            r_idx  <= '0;
            r_sumx <= '0;
            r_sumy <= '0;
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.diff) begin
            r_r    <= reach;
            r_mx   <= mx[31:0];
            r_my   <= my[31:0];
            r_negx <= dx[32];
            r_negy <= dy[32];
            r_far  <= (mx >= {1'b0, reach}) || (my >= {1'b0, reach});
        end
        if (i_cmd.sq_x) begin
            r_sx <= mul_res;
        end
        if (i_cmd.sq_y) begin
            r_sy <= mul_res;
        end
        if (i_cmd.sum) begin
            r_ovf     <= d2[64];
            r_sq_rad  <= d2[63:0];
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end
        if (i_cmd.sq_step) begin
            r_sq_rad  <= {r_sq_rad[61:0], 2'b00};
            r_sq_rem  <= sq_ge ? sq_diff[33:0] : sq_rem2[33:0];
            r_sq_root <= {r_sq_root[30:0], sq_ge};
        end
        if (i_cmd.ld_u) begin
            r_drem <= {1'b0, m_sel[31:1]};
            r_dlo  <= {m_sel[0], 16'd0};
            r_ddiv <= r_sq_root;
        end
        if (i_cmd.ld_t) begin
            r_drem <= prod_t[48:17];
            r_dlo  <= prod_t[16:0];
            r_ddiv <= r_r;
        end
        if (i_cmd.div_step) begin
            r_drem <= dv_ge ? dv_diff[31:0] : dv_tmp[31:0];
            r_dlo  <= {r_dlo[DIV_STEPS-2:0], dv_ge};
        end
        if (i_cmd.acc) begin
            if (i_cmd.comp_y) begin
                r_sumy <= r_sumy + term;
            end else begin
                r_sumx <= r_sumx + term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.table_op) begin
            if (r_op[OP_CLEAR_BIT]) begin
                o_status <= ST_CLEARED;
            end else if (!full) begin
                o_status <= ST_STORED;
            end else begin
                o_status <= ST_DROPPED;
            end
            o_adjusted_x   <= '0;
            o_adjusted_y   <= '0;
            o_saturated    <= 1'b0;
            o_stored_count <= n_count;
        end
        if (i_cmd.emit_adj) begin
            o_status       <= ST_ADJUSTED;
            o_adjusted_x   <= clip_x[31:0];
            o_adjusted_y   <= clip_y[31:0];
            o_saturated    <= clip_x[32] || clip_y[32];
            o_stored_count <= r_count;
        end
    end

    assign o_sts.adjust = r_op[OP_ADJUST_BIT];
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.far    = r_far;
    assign o_sts.reject = r_ovf || (r_sq_root >= r_r) || (r_sq_root <= NEAR_LIMIT);
    assign o_sts.last   = ((CNT_W'(r_idx) + 1'b1) == r_count);

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_OBSTACLES))
        else $error("obstacle count beyond table depth");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.table_op && full && !r_op[OP_CLEAR_BIT]) |=> (r_count == $past(r_count)))
        else $error("dropped obstacle changed the count");
`endif

endmodule

// ===== hw/rtl/obstacle_repulsion_adjuster.sv =====
// ----------------------------------------------------------------------------
// Obstacle repulsion adjuster
// Adjusts trajectory points away from a table of circular obstacles.
// ----------------------------------------------------------------------------
// Add and clear transactions pass the decode state and show a registered result.
// An adjust transaction visits each stored obstacle in turn: one out of reach
// is skipped early, one rejected after the distance goes no further, and one that
// repels runs the 32-step square root and four 17-step divisions of the shared unit.
// Busy stays high until the result is shown; the result strobe lasts one cycle.
// Synchronous active-low reset empties the table and restores the margin.
module obstacle_repulsion_adjuster import ora_pkg::*; #(
    parameter  int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [COORD_W-1:0]  i_pos_x,
    input  logic signed [COORD_W-1:0]  i_pos_y,
    input  logic [RADIUS_W-1:0]        i_obstacle_radius,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [RADIUS_W-1:0]        i_cfg_data,
    output logic                       o_result_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [COORD_W-1:0]  o_adjusted_x,
    output logic signed [COORD_W-1:0]  o_adjusted_y,
    output logic                       o_saturated,
    output logic [CNT_W-1:0]           o_stored_count
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ora_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ora_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_op),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_obstacle_radius (i_obstacle_radius),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_result_valid),
        .o_status          (o_status),
        .o_adjusted_x      (o_adjusted_x),
        .o_adjusted_y      (o_adjusted_y),
        .o_saturated       (o_saturated),
        .o_stored_count    (o_stored_count)
    );

endmodule
